// File: rtl/sbdt_pkg.sv
// shared types, constants and the decimal adjust-and-shift step for the
// signed binary to decimal text block; no dependencies
`timescale 1ns / 1ps

package sbdt_pkg;

    localparam int VALUE_W        = 16;
    localparam int DIGITS         = 5;
    localparam int DIGIT_W        = 4;
    localparam int BCD_W          = DIGITS * DIGIT_W;
    localparam int CHAR_W         = 8;
    localparam int BITS_PER_STEP  = 2;
    localparam int CONV_STEPS     = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W         = $clog2(CONV_STEPS);
    localparam int DIDX_W         = $clog2(DIGITS);
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    localparam logic [DIGIT_W-1:0] ADJ_LIMIT = 4'd5;
    localparam logic [DIGIT_W-1:0] ADJ_ADD   = 4'd3;

    // classified item: sign and magnitude
    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } t_item;

    // converted item: sign and five decimal digits, most significant on top
    typedef struct packed {
        logic             neg;
        logic [BCD_W-1:0] bcd;
    } t_conv_res;

    // shift-add-3 over BITS_PER_STEP input bits, msb first
    function automatic logic [BCD_W-1:0] f_dabble(
        input logic [BCD_W-1:0]         bcd_in,
        input logic [BITS_PER_STEP-1:0] bits_in
    );
        logic [BCD_W-1:0]   b;
        logic [DIGIT_W-1:0] d;
        b = bcd_in;
        for (int s = BITS_PER_STEP - 1; s >= 0; s--) begin
            for (int k = 0; k < DIGITS; k++) begin
                d = b[k*DIGIT_W +: DIGIT_W];
                if (d >= ADJ_LIMIT) begin
                    b[k*DIGIT_W +: DIGIT_W] = d + ADJ_ADD;
                end
            end
            b = {b[BCD_W-2:0], bits_in[s]};
        end
        return b;
    endfunction

endpackage

// File: rtl/sbdt_front.sv
// front end: accepts values, splits sign and magnitude, queues them
// depends on sbdt_pkg
`timescale 1ns / 1ps

module sbdt_front #(
    parameter int QUEUE_DEPTH = sbdt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [sbdt_pkg::VALUE_W-1:0] i_value,
    output logic                              o_item_valid,
    output sbdt_pkg::t_item                   o_item,
    input  logic                              i_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    sbdt_pkg::t_item r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push, pop;
    sbdt_pkg::t_item  item_in;

    // magnitude of the most negative value still fits in 16 unsigned bits
    always_comb begin
        item_in.neg = i_value[sbdt_pkg::VALUE_W-1];
        item_in.mag = item_in.neg ? (~i_value + 1'b1) : i_value;
    end

    assign o_stall      = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_mem[r_rd_ptr];
    assign push         = i_valid && !o_stall;
    assign pop          = o_item_valid && i_pop;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= item_in;
        end
    end

endmodule

// File: rtl/sbdt_conv.sv
// binary to decimal converter: two magnitude bits per cycle, the last step waiting for a free result slot
// depends on sbdt_pkg
`timescale 1ns / 1ps

module sbdt_conv (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_item_valid,
    input  sbdt_pkg::t_item      i_item,
    output logic                 o_pop,
    output logic                 o_res_valid,
    output sbdt_pkg::t_conv_res  o_res,
    input  logic                 i_res_take
);

    logic                              r_busy;
    logic [sbdt_pkg::STEP_W-1:0]       r_cnt;
    logic [sbdt_pkg::VALUE_W-1:0]      r_bin;
    logic [sbdt_pkg::BCD_W-1:0]        r_bcd;
    logic                              r_neg;
    logic                              r_res_valid;
    sbdt_pkg::t_conv_res               r_res;
    logic [sbdt_pkg::BCD_W-1:0]        n_bcd;
    logic                              last_step;
    logic                              finish;
    logic                              advance;

    // the last step waits for a free result slot; the next item loads on
    // the finishing edge so the loop runs without a bubble
    assign last_step = r_busy && (r_cnt == sbdt_pkg::STEP_W'(sbdt_pkg::CONV_STEPS - 1));
    assign finish    = last_step && (!r_res_valid || i_res_take);
    assign advance   = r_busy && (!last_step || finish);
    assign o_pop     = i_item_valid && (!r_busy || finish);
    assign n_bcd     = sbdt_pkg::f_dabble(
                           r_bcd, r_bin[sbdt_pkg::VALUE_W-1 -: sbdt_pkg::BITS_PER_STEP]);

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (advance) begin
                r_cnt <= r_cnt + 1'b1;
                if (last_step) begin
                    r_busy <= 1'b0;
                end
            end
            if (finish) begin
                r_res_valid <= 1'b1;
            end else if (i_res_take) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bin <= i_item.mag;
            r_bcd <= '0;
            r_neg <= i_item.neg;
        end else if (advance) begin
            r_bin <= r_bin << sbdt_pkg::BITS_PER_STEP;
            r_bcd <= n_bcd;
        end
        if (finish) begin
            r_res.neg <= r_neg;
            r_res.bcd <= n_bcd;
        end
    end

endmodule

// File: rtl/sbdt_emit.sv
// character sequencer: space, optional minus, five digits, closing space
// depends on sbdt_pkg
`timescale 1ns / 1ps

module sbdt_emit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_res_valid,
    input  sbdt_pkg::t_conv_res           i_res,
    output logic                          o_res_take,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [sbdt_pkg::CHAR_W-1:0]   o_char_code,
    output logic                          o_last_char
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SIGN  = 4'b0010,
        S_DIGIT = 4'b0100,
        S_TRAIL = 4'b1000
    } t_state;

    t_state                            r_state, n_state;
    logic [sbdt_pkg::DIDX_W-1:0]       r_didx, n_didx;
    logic [sbdt_pkg::BCD_W-1:0]        r_bcd, n_bcd;
    logic                              r_valid, n_valid;
    logic [sbdt_pkg::CHAR_W-1:0]       r_char, n_char;
    logic                              r_last, n_last;
    logic                              out_free;
    logic [sbdt_pkg::DIGIT_W-1:0]      top_digit;

    assign out_free  = !r_valid || !i_stall;
    assign top_digit = r_bcd[sbdt_pkg::BCD_W-1 -: sbdt_pkg::DIGIT_W];

    always_comb begin
        n_state    = r_state;
        n_didx     = r_didx;
        n_bcd      = r_bcd;
        n_valid    = r_valid;
        n_char     = r_char;
        n_last     = r_last;
        o_res_take = 1'b0;
        if (out_free) begin
            n_valid = 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_res_valid) begin
                        o_res_take = 1'b1;
                        n_bcd      = i_res.bcd;
                        n_didx     = '0;
                        n_valid    = 1'b1;
                        n_char     = sbdt_pkg::CH_SPACE;
                        n_last     = 1'b0;
                        n_state    = i_res.neg ? S_SIGN : S_DIGIT;
                    end
                end
                S_SIGN: begin
                    n_valid = 1'b1;
                    n_char  = sbdt_pkg::CH_MINUS;
                    n_last  = 1'b0;
                    n_state = S_DIGIT;
                end
                S_DIGIT: begin
                    n_valid = 1'b1;
                    n_char  = sbdt_pkg::CH_ZERO
                              + {{(sbdt_pkg::CHAR_W - sbdt_pkg::DIGIT_W){1'b0}}, top_digit};
                    n_last  = 1'b0;
                    n_bcd   = r_bcd << sbdt_pkg::DIGIT_W;
                    n_didx  = r_didx + 1'b1;
                    if (r_didx == sbdt_pkg::DIDX_W'(sbdt_pkg::DIGITS - 1)) begin
                        n_state = S_TRAIL;
                    end
                end
                S_TRAIL: begin
                    n_valid = 1'b1;
                    n_char  = sbdt_pkg::CH_SPACE;
                    n_last  = 1'b1;
                    n_state = S_IDLE;
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_didx  <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_didx  <= n_didx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd  <= n_bcd;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_valid     = r_valid;
    assign o_char_code = r_char;
    assign o_last_char = r_last;

endmodule

// File: rtl/signed_binary_to_decimal_text.sv
// signed binary to decimal text, top level
// input channel: i_valid / o_stall with i_value, a signed 16-bit number;
// a transaction completes on a clock edge with i_valid high and o_stall low
// output channel: o_valid / i_stall with o_char_code and o_last_char, one
// ascii character per transaction: a space, a minus sign for negative values,
// five digits most significant first with leading zeros, and a closing space
// flagged by o_last_char; 7 characters per value, 8 when negative
// a value passes through the queue, the converter loop at two magnitude bits per
// cycle, its result register (the last step waits while it is full) and the output register
// the converter loop sets the throughput; the converter works on the next
// value while the sequencer sends the last
// a receiver stall holds the output register; the queue keeps taking values
// until it is full, then o_stall rises
// reset (i_rst_n low, synchronous) empties the queue and idles both stages;
// no state carries from one value to the next
// depends on sbdt_pkg, sbdt_front, sbdt_conv, sbdt_emit
`timescale 1ns / 1ps

module signed_binary_to_decimal_text #(
    parameter int QUEUE_DEPTH = sbdt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [sbdt_pkg::VALUE_W-1:0] i_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [sbdt_pkg::CHAR_W-1:0]         o_char_code,
    output logic                                o_last_char
);

    // front to converter
    logic                 item_valid;
    sbdt_pkg::t_item      item;
    logic                 item_pop;

    // converter to sequencer
    logic                 res_valid;
    sbdt_pkg::t_conv_res  res;
    logic                 res_take;

    sbdt_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_value      (i_value),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_pop        (item_pop)
    );

    sbdt_conv u_conv (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_pop        (item_pop),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_take   (res_take)
    );

    sbdt_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_res_valid  (res_valid),
        .i_res        (res),
        .o_res_take   (res_take),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_char_code  (o_char_code),
        .o_last_char  (o_last_char)
    );

    // output register is empty after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // only the closing space ends a transaction run
    a_last_is_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_char |-> o_char_code == sbdt_pkg::CH_SPACE)
        else $error("last character is not a space");

    // every character is a space, a minus sign or a decimal digit
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_char_code == sbdt_pkg::CH_SPACE)
                 || (o_char_code == sbdt_pkg::CH_MINUS)
                 || ((o_char_code >= sbdt_pkg::CH_ZERO)
                     && (o_char_code <= sbdt_pkg::CH_NINE)))
        else $error("character outside the output set");

    // a result is taken only when one is valid and the output register is free
    a_take_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_take |-> res_valid && (!o_valid || !i_stall))
        else $error("result taken without a free output register");

endmodule

// File: tb/signed_binary_to_decimal_text_test.sv
// self-checking testbench for signed_binary_to_decimal_text: random-gap driver,
// random-stall monitor and a digit-vector predictor of the character stream
// depends on sbdt_pkg and the signed_binary_to_decimal_text rtl
`timescale 1ns / 1ps

module signed_binary_to_decimal_text_test;

    localparam int RANDOM_ITEMS     = 500;
    localparam int MAX_WAIT         = 13;
    localparam int RESET_CYCLES     = 8;
    localparam int END_DRAIN_CYCLES = 40;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int MAX_REPORTS      = 10;

    // one character of the printed text
    typedef struct packed {
        logic [sbdt_pkg::CHAR_W-1:0] code;
        logic                        last;
    } t_text_char;

    logic                                i_clk   = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_valid = 1'b0;
    logic                                o_stall;
    logic signed [sbdt_pkg::VALUE_W-1:0] i_value = '0;
    logic                                o_valid;
    logic                                i_stall = 1'b0;
    logic [sbdt_pkg::CHAR_W-1:0]         o_char_code;
    logic                                o_last_char;

    logic signed [sbdt_pkg::VALUE_W-1:0] values_to_send[$];
    t_text_char                          expected_chars[$];

    int  send_wait    = 0;
    int  recv_wait    = 0;
    bit  send_quiet   = 1'b0;
    bit  recv_quiet   = 1'b0;
    int  error_count  = 0;
    int  idle_cycles  = 0;

    signed_binary_to_decimal_text dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

    always #5 i_clk = ~i_clk;

    // decimal digits of 2^i packed as bcd, most significant digit on top
    function automatic logic [sbdt_pkg::BCD_W-1:0] pow2_bcd(input int i);
        case (i)
            0:  return 20'h00001;
            1:  return 20'h00002;
            2:  return 20'h00004;
            3:  return 20'h00008;
            4:  return 20'h00016;
            5:  return 20'h00032;
            6:  return 20'h00064;
            7:  return 20'h00128;
            8:  return 20'h00256;
            9:  return 20'h00512;
            10: return 20'h01024;
            11: return 20'h02048;
            12: return 20'h04096;
            13: return 20'h08192;
            14: return 20'h16384;
            default: return 20'h32768;
        endcase
    endfunction

    function automatic t_text_char make_char(input logic [sbdt_pkg::CHAR_W-1:0] code,
                                             input logic last);
        t_text_char c;
        c.code = code;
        c.last = last;
        return c;
    endfunction

    // builds the expected text of one value and queues it character by character
    function automatic void predict_text(input logic signed [sbdt_pkg::VALUE_W-1:0] value);
        logic                          neg;
        logic [sbdt_pkg::VALUE_W-1:0]  mag;
        logic [sbdt_pkg::BCD_W-1:0]    acc;
        logic [sbdt_pkg::BCD_W-1:0]    addend;
        logic [sbdt_pkg::DIGIT_W:0]    digit_sum;
        logic                          carry;
        neg = value[sbdt_pkg::VALUE_W-1];
        mag = neg ? -value : value;
        acc = '0;
        // add the digit vector of every set magnitude bit, rippling decimal carries
        for (int i = 0; i < sbdt_pkg::VALUE_W; i++) begin
            if (mag[i]) begin
                addend = pow2_bcd(i);
                carry  = 1'b0;
                for (int k = 0; k < sbdt_pkg::DIGITS; k++) begin
                    digit_sum = acc[k*sbdt_pkg::DIGIT_W +: sbdt_pkg::DIGIT_W]
                              + addend[k*sbdt_pkg::DIGIT_W +: sbdt_pkg::DIGIT_W]
                              + carry;
                    if (digit_sum >= 5'd10) begin
                        digit_sum = digit_sum - 5'd10;
                        carry     = 1'b1;
                    end else begin
                        carry = 1'b0;
                    end
                    acc[k*sbdt_pkg::DIGIT_W +: sbdt_pkg::DIGIT_W] =
                        digit_sum[sbdt_pkg::DIGIT_W-1:0];
                end
            end
        end
        expected_chars.push_back(make_char(sbdt_pkg::CH_SPACE, 1'b0));
        if (neg) begin
            expected_chars.push_back(make_char(sbdt_pkg::CH_MINUS, 1'b0));
        end
        for (int k = sbdt_pkg::DIGITS - 1; k >= 0; k--) begin
            expected_chars.push_back(make_char(
                sbdt_pkg::CH_ZERO + acc[k*sbdt_pkg::DIGIT_W +: sbdt_pkg::DIGIT_W], 1'b0));
        end
        expected_chars.push_back(make_char(sbdt_pkg::CH_SPACE, 1'b1));
    endfunction

    // random value biased toward digit boundaries, small numbers and the extremes
    function automatic logic signed [sbdt_pkg::VALUE_W-1:0] random_value();
        int v;
        int decade;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $urandom_range(0, 99);
            2: v = 32767 - $urandom_range(0, 15);
            default: begin
                decade = 1;
                for (int k = $urandom_range(0, 4); k > 0; k--) begin
                    decade = decade * 10;
                end
                v = decade + $urandom_range(0, 2) - 1;
            end
        endcase
        // random sign; the extreme band flips to the most negative end
        if ($urandom_range(0, 1)) begin
            v = -v - 1 + $urandom_range(0, 1);
        end
        return v[sbdt_pkg::VALUE_W-1:0];
    endfunction

    // driver: sends queued values with a random gap drawn after each transaction
    always @(posedge i_clk) begin : driver
        int gap;
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            send_wait <= 0;
        end else if (i_valid && !o_stall) begin
            // value taken at this edge, so its characters are now expected
            predict_text(i_value);
            if ($urandom_range(0, 31) == 0) begin
                send_quiet <= !send_quiet;
            end
            gap = send_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            if (gap == 0 && values_to_send.size() != 0) begin
                // back-to-back: valid stays high, only the payload moves on
                i_value <= values_to_send.pop_front();
            end else begin
                i_valid   <= 1'b0;
                send_wait <= gap;
            end
        end else if (!i_valid) begin
            if (send_wait != 0) begin
                send_wait <= send_wait - 1;
            end else if (values_to_send.size() != 0) begin
                i_valid <= 1'b1;
                i_value <= values_to_send.pop_front();
            end
        end
    end

    // monitor: checks each character against the oldest expectation, then
    // holds stall high for a random number of cycles before the next one
    always @(posedge i_clk) begin : monitor
        int         hold;
        t_text_char want;
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            recv_wait <= 0;
        end else if (o_valid && !i_stall) begin
            if (expected_chars.size() == 0) begin
                error_count = error_count + 1;
                if (error_count <= MAX_REPORTS) begin
                    $display("%0t: unexpected character code=%02h last=%0b",
                             $realtime, o_char_code, o_last_char);
                end
            end else begin
                want = expected_chars.pop_front();
                if (o_char_code !== want.code || o_last_char !== want.last) begin
                    error_count = error_count + 1;
                    if (error_count <= MAX_REPORTS) begin
                        $display("%0t: char mismatch code exp=%02h got=%02h last exp=%0b got=%0b",
                                 $realtime, want.code, o_char_code, want.last, o_last_char);
                    end
                end
            end
            if ($urandom_range(0, 31) == 0) begin
                recv_quiet <= !recv_quiet;
            end
            hold = recv_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            if (hold != 0) begin
                i_stall   <= 1'b1;
                recv_wait <= hold - 1;
            end
        end else if (i_stall) begin
            if (recv_wait == 0) begin
                i_stall <= 1'b0;
            end else begin
                recv_wait <= recv_wait - 1;
            end
        end
    end

    // watchdog: too long without a transaction on either channel means a hang
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : sequencer
        // directed values: zero, unit steps, extremes, digit boundaries, carry patterns
        values_to_send.push_back(16'sd0);
        values_to_send.push_back(16'sd1);
        values_to_send.push_back(-16'sd1);
        values_to_send.push_back(16'sd32767);
        values_to_send.push_back(-16'sd32768);   // most negative value, full magnitude
        values_to_send.push_back(-16'sd32767);
        values_to_send.push_back(16'sd9);
        values_to_send.push_back(16'sd10);
        values_to_send.push_back(16'sd99);
        values_to_send.push_back(16'sd100);
        values_to_send.push_back(-16'sd10);
        values_to_send.push_back(16'sd9999);
        values_to_send.push_back(16'sd10000);
        values_to_send.push_back(-16'sd9999);
        values_to_send.push_back(16'sd12345);
        values_to_send.push_back(-16'sd12345);
        values_to_send.push_back(16'sd16384);
        values_to_send.push_back(-16'sd16384);
        values_to_send.push_back(16'h5555);
        values_to_send.push_back(16'hAAAA);
        values_to_send.push_back(16'sd29999);
        values_to_send.push_back(16'sd19999);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            values_to_send.push_back(random_value());
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all values taken, then all characters back, then a quiet tail
        while (values_to_send.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (END_DRAIN_CYCLES) @(posedge i_clk);

        if (expected_chars.size() != 0) begin
            error_count = error_count + 1;
        end
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", error_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
